// ----- rtl/assert_macros.svh -----
// Assertion macros, included by b64e_serializer.sv.
// Each macro takes a label, a property expression and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- rtl/b64e_pkg.sv -----
package b64e_pkg;

   // Position of the next byte inside its three-byte group.
   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2
   } phase_type;

   // Fixed characters.
   localparam logic [7:0] PAD_CHAR = 8'd61;
   localparam logic [7:0] CR_CHAR  = 8'd13;
   localparam logic [7:0] LF_CHAR  = 8'd10;

   // Reset value of the line length register, in groups.
   localparam logic [7:0] GROUPS_PER_LINE_RESET = 8'd18;

   // All characters caused by one input byte.
   typedef struct packed {
      logic [3:0][7:0] chars;     // chars[0] goes out first
      logic [1:0]      last_idx;  // index of the final character
   } bundle_type;

   // Maps a 6-bit value onto the standard base64 alphabet.
   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] wide;
      begin
         wide = {2'b00, v};
         if (v < 6'd26) begin
            sym = wide + 8'd65;
         end else if (v < 6'd52) begin
            sym = wide + 8'd71;
         end else if (v < 6'd62) begin
            sym = wide - 8'd4;
         end else if (v == 6'd62) begin
            sym = 8'd43;
         end else begin
            sym = 8'd47;
         end
      end
   endfunction

endpackage

// ----- rtl/b64e_if.sv -----
// Input channel: one raw byte per transfer.
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel: one character per transfer.
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;
   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// Configuration channel: writes the line length register.
interface b64e_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] groups_per_line;
   modport source (output valid, output groups_per_line, input ready);
   modport sink   (input valid, input groups_per_line, output ready);
endinterface

// ----- rtl/base64_line_wrapped_encoder.sv -----
// Channel   Port     Direction  Payload
// input     req_ch   sink       data_byte[7:0], last_byte
// result    rsp_ch   source     out_char[7:0], last_char
// config    csr_ch   sink       groups_per_line[7:0]
//
// A byte is encoded in the cycle it is taken; its one to four characters then
// leave from the result register at one per cycle while the result side is
// ready, and a byte yields about 1.4 characters on average.
// The next byte is taken in the cycle the final character of the previous one
// transfers. Synchronous reset empties the result register, clears the group
// state and sets groups_per_line to 18. A stall on the result side holds the
// current character and backs up into the input channel.
module base64_line_wrapped_encoder (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_ch,
   b64e_rsp_if.source  rsp_ch,
   b64e_csr_if.sink    csr_ch
);

   logic                 load_valid;
   logic                 load_ready;
   b64e_pkg::bundle_type load_bundle;

   b64e_core u_core (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .load_ready  (load_ready),
      .load_valid  (load_valid),
      .load_bundle (load_bundle)
   );

   b64e_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (load_valid),
      .load_bundle (load_bundle),
      .load_ready  (load_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ----- rtl/b64e_core.sv -----
module b64e_core (
   input  logic                clock,
   input  logic                reset,
   b64e_req_if.sink            req_ch,
   b64e_csr_if.sink            csr_ch,
   input  logic                load_ready,
   output logic                load_valid,
   output b64e_pkg::bundle_type load_bundle
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          held_ff, held_in;
   logic [7:0]          line_cnt_ff, line_cnt_in;
   logic [7:0]          gpl_ff;
   logic [7:0]          cnt_inc;
   logic                wrap;
   logic [7:0]          b;

   // The configuration register takes every write at once.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gpl_ff <= b64e_pkg::GROUPS_PER_LINE_RESET;
      end else if (csr_ch.valid) begin
         gpl_ff <= csr_ch.groups_per_line;
      end
   end

   // A byte is taken whenever the serializer can load its characters.
   assign req_ch.ready = load_ready;
   assign load_valid   = req_ch.valid & load_ready;
   assign b            = req_ch.data_byte;

   // Line wrap decision for a completed group.
   assign cnt_inc = line_cnt_ff + 8'd1;
   assign wrap    = (gpl_ff != 8'd0) && (cnt_inc >= gpl_ff);

   // Character generation and next state for the offered byte.
   always_comb begin
      load_bundle = '0;
      phase_in    = phase_ff;
      held_in     = held_ff;
      line_cnt_in = line_cnt_ff;
      unique case (phase_ff)
         b64e_pkg::PH_SECOND: begin
            load_bundle.chars[0] = b64e_pkg::sym({held_ff[1:0], b[7:4]});
            if (req_ch.last_byte) begin
               load_bundle.chars[1] = b64e_pkg::sym({b[3:0], 2'b00});
               load_bundle.chars[2] = b64e_pkg::PAD_CHAR;
               load_bundle.last_idx = 2'd2;
               phase_in    = b64e_pkg::PH_FIRST;
               held_in     = 4'd0;
               line_cnt_in = 8'd0;
            end else begin
               load_bundle.last_idx = 2'd0;
               phase_in = b64e_pkg::PH_THIRD;
               held_in  = b[3:0];
            end
         end
         b64e_pkg::PH_THIRD: begin
            load_bundle.chars[0] = b64e_pkg::sym({held_ff, b[7:6]});
            load_bundle.chars[1] = b64e_pkg::sym(b[5:0]);
            load_bundle.last_idx = 2'd1;
            phase_in = b64e_pkg::PH_FIRST;
            held_in  = 4'd0;
            if (req_ch.last_byte) begin
               line_cnt_in = 8'd0;
            end else if (wrap) begin
               load_bundle.chars[2] = b64e_pkg::CR_CHAR;
               load_bundle.chars[3] = b64e_pkg::LF_CHAR;
               load_bundle.last_idx = 2'd3;
               line_cnt_in = 8'd0;
            end else if (gpl_ff != 8'd0) begin
               line_cnt_in = cnt_inc;
            end else begin
               line_cnt_in = 8'd0;
            end
         end
         default: begin
            load_bundle.chars[0] = b64e_pkg::sym(b[7:2]);
            if (req_ch.last_byte) begin
               load_bundle.chars[1] = b64e_pkg::sym({b[1:0], 4'b0000});
               load_bundle.chars[2] = b64e_pkg::PAD_CHAR;
               load_bundle.chars[3] = b64e_pkg::PAD_CHAR;
               load_bundle.last_idx = 2'd3;
               phase_in    = b64e_pkg::PH_FIRST;
               held_in     = 4'd0;
               line_cnt_in = 8'd0;
            end else begin
               load_bundle.last_idx = 2'd0;
               phase_in = b64e_pkg::PH_SECOND;
               held_in  = {2'b00, b[1:0]};
            end
         end
      endcase
   end

   // Encoder state advances on each input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64e_pkg::PH_FIRST;
         held_ff     <= 4'd0;
         line_cnt_ff <= 8'd0;
      end else if (load_valid) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         line_cnt_ff <= line_cnt_in;
      end
   end

endmodule

// ----- rtl/b64e_serializer.sv -----
`include "assert_macros.svh"

module b64e_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  b64e_pkg::bundle_type load_bundle,
   output logic                load_ready,
   b64e_rsp_if.source          rsp_ch
);

   b64e_pkg::bundle_type bundle_ff;
   logic [1:0]           idx_ff;
   logic                 full_ff;
   logic                 at_last;
   logic                 drain;

   // The final character of the held bundle leaves on this edge.
   assign at_last    = (idx_ff == bundle_ff.last_idx);
   assign drain      = full_ff & rsp_ch.ready & at_last;
   assign load_ready = ~full_ff | drain;

   assign rsp_ch.valid     = full_ff;
   assign rsp_ch.out_char  = bundle_ff.chars[idx_ff];
   assign rsp_ch.last_char = at_last;

   // Control: fill flag and character index.
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (load_valid) begin
         full_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (drain) begin
         full_ff <= 1'b0;
      end else if (full_ff && rsp_ch.ready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   // Payload of the held bundle.
   always_ff @(posedge clock) begin
      if (load_valid) begin
         bundle_ff <= load_bundle;
      end
   end

   `ASSERT_CLKD(a_idx_in_range, full_ff |-> (idx_ff <= bundle_ff.last_idx), "index past last character")
   `ASSERT_CLKD(a_load_only_free, (load_valid && full_ff) |-> drain, "bundle overwritten before drained")
   `ASSERT_CLKD(a_empty_after_drain, (drain && !load_valid) |=> !full_ff, "valid held after final character")
   `ASSERT_ALWAYS(a_reset_empty, reset |=> !full_ff, "result pending after reset")

endmodule
